[hdl/assert_macros.svh]
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error("assertion failed");
`endif

[hdl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
  localparam int unsigned MsgLenBits = 61;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_LAST  = 2'd1,
    CMD_EMPTY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic       is_end;
    logic       has_byte;
    logic [7:0] data;
  } op_t;

  localparam logic [31:0] Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] Kc [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction
  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction
  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction
  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction
endpackage
`default_nettype wire

[hdl/sha_stream_if.sv]
// ----------------------------------------------------------------------------
// sha_stream_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

[hdl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256 over a byte stream with hardware padding.
// ----------------------------------------------------------------------------
// Bytes are taken one per transfer into a small command queue; the back end
// stores one byte per cycle while it is loading and runs 64 rounds plus an
// add step on each full 64-byte block. The end of a message adds padding
// and one or two compressions, then eight digest word transfers.
`default_nettype none
module sha256_stream_hasher #(
  parameter int unsigned MESSAGE_LENGTH_BITS = sha_pkg::MsgLenBits,
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  sha_pkg::op_t op;
  logic op_valid, op_ready;

  sha_front #(.Depth(QUEUE_DEPTH)) u_front (
    .clk_i, .rst_ni, .in_i, .op_o(op), .op_valid_o(op_valid), .op_ready_i(op_ready));
  sha_back #(.LenBits(MESSAGE_LENGTH_BITS)) u_back (
    .clk_i, .rst_ni, .op_i(op), .op_valid_i(op_valid), .op_ready_o(op_ready), .out_o);
endmodule
`default_nettype wire

[hdl/sha_front.sv]
// ----------------------------------------------------------------------------
// sha_front
// Classifies incoming commands and queues byte/end operations.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_front #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sha_in_if.sink        in_i,
  output sha_pkg::op_t  op_o,
  output logic          op_valid_o,
  input  wire logic     op_ready_i
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  sha_pkg::op_t    mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;
  logic            push, pop, drop;
  sha_pkg::op_t    op_new;

  always_comb begin
    op_new.data     = in_i.data_byte;
    op_new.has_byte = (in_i.command == sha_pkg::CMD_BYTE) ||
                      (in_i.command == sha_pkg::CMD_LAST);
    op_new.is_end   = (in_i.command == sha_pkg::CMD_LAST) ||
                      (in_i.command == sha_pkg::CMD_EMPTY);
  end

  assign in_i.ready = (cnt_q != (AW+1)'(Depth));
  assign drop       = (in_i.command == sha_pkg::CMD_NONE);
  assign push       = in_i.valid && in_i.ready && !drop;
  assign pop        = op_valid_o && op_ready_i;
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= op_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[hdl/sha_back.sv]
// ----------------------------------------------------------------------------
// sha_back
// Block assembly, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sha_back #(
  parameter int unsigned LenBits = sha_pkg::MsgLenBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire sha_pkg::op_t op_i,
  input  wire logic         op_valid_i,
  output logic              op_ready_o,
  sha_out_if.source         out_o
);
  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_RND  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_OUT  = 5'b10000
  } st_e;

  st_e                st_q, st_d;
  logic [511:0]       blk_q;
  logic [5:0]         pos_q;
  logic [5:0]         pos_next;
  logic [LenBits-1:0] len_q;
  logic [31:0]        h_q [8];
  logic [31:0]        v_q [8];
  logic [31:0]        w_win [16];
  logic [5:0]         rnd_q;
  logic               fin_q;
  logic               mark_q;
  logic               extra_q;
  logic [2:0]         oidx_q;
  logic [63:0]        bits;
  logic [7:0]         pad_byte;
  logic [31:0]        w_cur, t1, t2;

  // blk_q is a byte shift register while loading and the schedule window
  // during rounds: word i of the window sits at blk_q[511-32*i -: 32].
  always_comb begin
    for (int i = 0; i < 16; i++) w_win[i] = blk_q[511 - 32*i -: 32];
  end

  assign bits       = 64'({len_q, 3'b000});
  assign pos_next   = op_i.has_byte ? pos_q + 6'd1 : pos_q;
  assign op_ready_o = (st_q == ST_LOAD);
  assign w_cur = (rnd_q < 6'd16) ? w_win[0] :
                 sha_pkg::ssig1(w_win[14]) + w_win[9] + sha_pkg::ssig0(w_win[1]) + w_win[0];
  assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha_pkg::Kc[rnd_q] + w_cur;
  assign t2 = sha_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^
              (v_q[1] & v_q[2]));

  // 0x80 first, then zeros; length bytes only in the block that carries them
  always_comb begin
    pad_byte = 8'h00;
    if (mark_q) pad_byte = 8'h80;
    else if (pos_q >= 6'd56 && !extra_q)
      pad_byte = bits[{3'd7 - pos_q[2:0], 3'b000} +: 8];
  end

  assign out_o.valid       = (st_q == ST_OUT);
  assign out_o.digest_word = h_q[oidx_q];
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = (oidx_q == 3'd7);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_LOAD: if (op_valid_i) begin
        if (op_i.has_byte && pos_q == 6'd63) st_d = ST_RND;
        else if (op_i.is_end) st_d = ST_PAD;
      end
      ST_PAD:  if (pos_q == 6'd63) st_d = ST_RND;
      ST_RND:  if (rnd_q == 6'd63) st_d = ST_ADD;
      ST_ADD: begin
        if (!fin_q) st_d = ST_LOAD;
        else if (mark_q || extra_q) st_d = ST_PAD;
        else st_d = ST_OUT;
      end
      ST_OUT:  if (out_o.ready && oidx_q == 3'd7) st_d = ST_LOAD;
      default: st_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_LOAD: if (op_valid_i && op_i.has_byte) blk_q <= {blk_q[503:0], op_i.data};
      ST_PAD:  blk_q <= {blk_q[503:0], pad_byte};
      ST_RND:  blk_q <= {blk_q[479:0], w_cur};
      default: ;
    endcase
    if (st_q == ST_RND) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if (st_d == ST_RND) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_LOAD;
      pos_q   <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      mark_q  <= 1'b0;
      extra_q <= 1'b0;
      oidx_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::Iv[i];
    end else begin
      st_q <= st_d;
      case (st_q)
        ST_LOAD: if (op_valid_i) begin
          if (op_i.has_byte) begin
            pos_q <= pos_q + 1'b1;
            len_q <= len_q + 1'b1;
          end
          if (op_i.is_end) begin
            fin_q   <= 1'b1;
            mark_q  <= 1'b1;
            extra_q <= (pos_next >= 6'd56);
          end
        end
        ST_PAD: begin
          pos_q  <= pos_q + 1'b1;
          mark_q <= 1'b0;
        end
        ST_RND: rnd_q <= rnd_q + 1'b1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          extra_q <= 1'b0;
        end
        ST_OUT: if (out_o.ready) begin
          oidx_q <= oidx_q + 1'b1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::Iv[i];
            len_q <= '0;
            fin_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_one_hot, $onehot(st_q))
  `ASSERT_CLK(a_out_idx, (out_o.valid && !out_o.ready) |=> $stable(oidx_q))
  `ASSERT_NEVER(a_rnd_ready, (st_q == ST_RND) && op_ready_o)
endmodule
`default_nettype wire
